// ===== hdl/tbdws_pkg.sv =====
package tbdws_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int TICK_W   = 16;
  localparam int N_W      = 7;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Output stream packing: sample, mean, std dev, samples used, total
  localparam int OUT_BITS = 3 * SAMPLE_W + N_W + TOTAL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Statistics datapath widths (window of up to 127 samples)
  localparam int SUM_W     = 23;  // 127 * 65535
  localparam int SQ_W      = 39;  // 127 * 65535^2
  localparam int NUM_W     = 46;  // n * sum of squares
  localparam int DEN_W     = 14;  // n * (n - 1)
  localparam int ROOT_W    = NUM_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 1;
  localparam int UNIT_W    = SQ_REM_W + 2;
  localparam int STEP_W    = 6;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = ROOT_W;

  // Reset values of the configuration registers
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [N_W-1:0]    WINDOW_RESET  = 7'd16;

  localparam logic [TICK_W-1:0]   TICK_MAX = '1;
  localparam logic [SAMPLE_W-1:0] SD_MAX   = '1;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 8'd1;

endpackage

// ===== hdl/two_byte_sample_deframer_window_stats_unit.sv =====
// Pairs received bytes (high byte first) into unsigned Q8.8 samples, keeps
// them in a history ring and, for each new sample, sends one transfer with
// the sample, the floor mean and the floor square root of the sample
// variance over the latest n = min(window_length, stored) samples, plus n
// and a wrapping sample count. Ticks, clears, unused commands and first
// bytes are taken while idle and give no transfer. A byte that completes
// a sample keeps s_tready low through the window read (one history
// read port), the mean division and a step to pick the path; for
// n >= 2 the variance numerator products, the variance division and
// the square root follow. The result then loads into the output
// register once it is free. The divisions and the square root share
// one compare-subtract unit. The finished result sits in an output
// register, so new input is taken while it waits on m_tready.
// History needs no clearing pass: only entries written since the last
// clear are ever read.
module two_byte_sample_deframer_window_stats_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbdws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbdws_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tbdws_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic [tbdws_pkg::CMD_W-1:0]       s_tuser,   // [1:0] command
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] sample_raw, [31:16] window_mean, [47:32] window_std_dev,
  // [54:48] samples_used, [86:55] total_samples, [87] zero
  output logic [tbdws_pkg::OUT_W-1:0]       m_tdata
);
  import tbdws_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > N_W) ? CNT_W : N_W;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(HISTORY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_DIVM, S_VSET, S_MULB, S_NUM, S_DIVV, S_SQSET, S_SQRT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [TICK_W-1:0] timeout_ms;
  logic [N_W-1:0]    window_length;

  // Deframer and ring state
  logic              byte_pending;
  logic [BYTE_W-1:0] first_byte;
  logic [TICK_W-1:0] ticks;
  logic [PTR_W-1:0]  write_pointer;
  logic [CNT_W-1:0]  stored_count;
  logic [TOTAL_W-1:0] sample_total;

  // History memory
  logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] mem_q;
  logic [PTR_W-1:0]    rd_ptr;
  logic                mem_we;
  logic [SAMPLE_W-1:0] sample_next;

  // Window accumulation
  logic [N_W-1:0]      n;
  logic [N_W-1:0]      issued;
  logic                rd_vld;
  logic                sq_vld;
  logic [SAMPLE_W-1:0] v_q;
  logic [2*SAMPLE_W-1:0] sq_q;
  logic [SUM_W-1:0]    win_sum;
  logic [SQ_W-1:0]     win_sq;

  // Division and square root
  logic [NUM_W-1:0]    prod_a;
  logic [NUM_W-1:0]    prod_b;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic [DEN_W-1:0]    div_rem;
  logic [NUM_W-1:0]    rad;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]   root;
  logic [STEP_W-1:0]   step;

  // Result fields
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] mean_q;

  // Shared compare-subtract unit
  logic [UNIT_W-1:0] unit_a;
  logic [UNIT_W-1:0] unit_b;
  logic [UNIT_W:0]   unit_diff;
  logic              unit_ge;

  // Accept-side decode
  logic             in_xfer;
  logic             pend_live;
  logic             completes;
  logic [PTR_W-1:0] wp_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [N_W-1:0]   wl_eff;
  logic [N_W-1:0]   n_next;
  logic             out_free;
  logic [SAMPLE_W-1:0] sd_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Byte pairing with inter-byte timeout
  assign pend_live   = byte_pending && !(ticks > timeout_ms);
  assign completes   = in_xfer && (cmd_t'(s_tuser) == CMD_BYTE) && pend_live;
  assign sample_next = {first_byte, s_tdata};
  assign mem_we      = completes;

  assign wp_inc  = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
  assign cnt_inc = (stored_count == CNT_FULL) ? stored_count : stored_count + 1'b1;
  assign wl_eff  = (window_length == '0) ? N_W'(1) : window_length;
  assign n_next  = (CMP_W'(cnt_inc) < CMP_W'(wl_eff)) ? N_W'(cnt_inc) : wl_eff;

  assign sd_sat = (root > ROOT_W'(SD_MAX)) ? SD_MAX : root[SAMPLE_W-1:0];

  // Operand select for the shared unit
  always_comb begin
    case (state)
      S_DIVM, S_DIVV: begin
        unit_a = UNIT_W'({div_rem, div_num[NUM_W-1]});
        unit_b = UNIT_W'(div_den);
      end
      S_SQRT: begin
        unit_a = {sq_rem, rad[NUM_W-1 -: 2]};
        unit_b = UNIT_W'({root, 2'b01});
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge   = !unit_diff[UNIT_W];

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_pointer] <= sample_next;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_ptr];
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      timeout_ms    <= TIMEOUT_RESET;
      window_length <= WINDOW_RESET;
      byte_pending  <= 1'b0;
      first_byte    <= '0;
      ticks         <= '0;
      write_pointer <= '0;
      stored_count  <= '0;
      sample_total  <= '0;
      rd_vld        <= 1'b0;
      sq_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TIMEOUT) begin
          timeout_ms <= cfg_data;
        end else if (cfg_index == REG_WINDOW) begin
          window_length <= cfg_data[N_W-1:0];
        end
      end

      // S_DONE reloads the output register in the same cycle
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      // window read pipeline: memory read, then square
      rd_vld <= (state == S_ACC) && (issued < n);
      sq_vld <= rd_vld;
      v_q    <= mem_q;
      sq_q   <= (2*SAMPLE_W)'(mem_q) * (2*SAMPLE_W)'(mem_q);
      if (sq_vld) begin
        win_sum <= win_sum + SUM_W'(v_q);
        win_sq  <= win_sq + SQ_W'(sq_q);
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (cmd_t'(s_tuser))
              CMD_TICK: begin
                if (ticks != TICK_MAX) begin
                  ticks <= ticks + 1'b1;
                end
              end
              CMD_CLEAR: begin
                write_pointer <= '0;
                stored_count  <= '0;
                byte_pending  <= 1'b0;
              end
              CMD_BYTE: begin
                ticks <= '0;
                if (!pend_live) begin
                  first_byte   <= s_tdata;
                  byte_pending <= 1'b1;
                end else begin
                  byte_pending  <= 1'b0;
                  sample_q      <= sample_next;
                  rd_ptr        <= write_pointer;
                  write_pointer <= wp_inc;
                  stored_count  <= cnt_inc;
                  sample_total  <= sample_total + 1'b1;
                  n             <= n_next;
                  issued        <= '0;
                  win_sum       <= '0;
                  win_sq        <= '0;
                  state         <= S_ACC;
                end
              end
              default: ;
            endcase
          end
        end

        // newest to oldest, one entry a cycle
        S_ACC: begin
          if (issued < n) begin
            issued <= issued + 1'b1;
            rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - 1'b1;
          end else if (!rd_vld && !sq_vld) begin
            div_num <= NUM_W'(win_sum);
            div_den <= DEN_W'(n);
            div_rem <= '0;
            step    <= STEP_W'(DIV_STEPS - 1);
            state   <= S_DIVM;
          end
        end

        // restoring division, one quotient bit a cycle
        S_DIVM, S_DIVV: begin
          div_num <= {div_num[NUM_W-2:0], unit_ge};
          div_rem <= unit_ge ? unit_diff[DEN_W-1:0] : unit_a[DEN_W-1:0];
          step    <= step - 1'b1;
          if (step == '0) begin
            state <= (state == S_DIVM) ? S_VSET : S_SQSET;
          end
        end

        S_VSET: begin
          mean_q <= div_num[SAMPLE_W-1:0];
          if (n < N_W'(2)) begin
            root  <= '0;
            state <= S_DONE;
          end else begin
            prod_a <= NUM_W'(n) * NUM_W'(win_sq);
            state  <= S_MULB;
          end
        end

        S_MULB: begin
          prod_b <= NUM_W'(win_sum) * NUM_W'(win_sum);
          state  <= S_NUM;
        end

        S_NUM: begin
          div_num <= prod_a - prod_b;
          div_den <= DEN_W'(n) * (DEN_W'(n) - DEN_W'(1));
          div_rem <= '0;
          step    <= STEP_W'(DIV_STEPS - 1);
          state   <= S_DIVV;
        end

        S_SQSET: begin
          rad    <= div_num;
          sq_rem <= '0;
          root   <= '0;
          step   <= STEP_W'(SQRT_STEPS - 1);
          state  <= S_SQRT;
        end

        // digit-by-digit square root, one root bit a cycle
        S_SQRT: begin
          rad    <= {rad[NUM_W-3:0], 2'b00};
          sq_rem <= unit_ge ? unit_diff[SQ_REM_W-1:0] : unit_a[SQ_REM_W-1:0];
          root   <= {root[ROOT_W-2:0], unit_ge};
          step   <= step - 1'b1;
          if (step == '0) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({sample_total, n, sd_sat, mean_q, sample_q});
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_FULL)
    else $error("stored sample count above history depth");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (n != '0) && (CMP_W'(n) <= CMP_W'(stored_count)))
    else $error("window size outside stored samples");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (issued <= n))
    else $error("more window reads issued than samples used");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVM || state == S_DIVV) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_tvalid && (state == S_IDLE))
    else $error("finished result not presented");

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbdws_pkg::*;

  localparam int          HIST_DEPTH = 64;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          MAX_REPORTS = 10;
  // command code outside the enum: the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one output transfer, laid out as m_tdata (sample in the low bits)
  typedef struct packed {
    logic                pad;
    logic [TOTAL_W-1:0]  total;
    logic [N_W-1:0]      used;
    logic [SAMPLE_W-1:0] sd;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] sample;
  } stats_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    bit                typed;
    stats_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;   // [7:0] data_byte
  logic [CMD_W-1:0]      s_tuser = '0;   // [1:0] command

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [15:0] sample_raw, [31:16] window_mean, [47:32] window_std_dev,
  // [54:48] samples_used, [86:55] total_samples, [87] zero
  logic [OUT_W-1:0]      m_tdata;

  two_byte_sample_deframer_window_stats_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the deframer and statistics state
  logic [TICK_W-1:0]   cfg_tmo = TIMEOUT_RESET;
  logic [N_W-1:0]      cfg_win = WINDOW_RESET;
  bit                  pend = 1'b0;
  logic [BYTE_W-1:0]   first_b = '0;
  logic [TICK_W-1:0]   ticks = '0;
  logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic [5:0]          wptr = '0;
  int unsigned         stored = 0;
  logic [TOTAL_W-1:0]  total = '0;

  stats_t   stats_due [$];
  dir_row_t dir_rows [$];
  int       failures = 0;
  int       items_sent = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       cycles = 0;
  stats_t   mon_got;
  stats_t   mon_want;

  // Apply one command to the shadow state; returns 1 when a sample completes
  function automatic bit advance_deframer(input logic [CMD_W-1:0] cmd,
                                          input logic [BYTE_W-1:0] data,
                                          output stats_t res);
    logic [SAMPLE_W-1:0] smp;
    logic [5:0]          idx;
    int unsigned         n;
    longint unsigned     s1, s2, v, var_q, root, trial;
    int                  k;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        if (ticks != TICK_MAX) ticks++;
        return 1'b0;
      end
      CMD_CLEAR: begin
        wptr = '0;
        stored = 0;
        pend = 1'b0;
        return 1'b0;
      end
      CMD_BYTE: ;
      default: return 1'b0;
    endcase

    // stale high byte is dropped, any byte restarts the gap count
    if (ticks > cfg_tmo) pend = 1'b0;
    ticks = '0;
    if (!pend) begin
      first_b = data;
      pend = 1'b1;
      return 1'b0;
    end
    pend = 1'b0;
    smp = {first_b, data};
    hist[wptr] = smp;
    wptr = wptr + 6'd1;
    if (stored < HIST_DEPTH) stored++;
    total = total + 1;

    n = (cfg_win == 0) ? 1 : cfg_win;
    if (n > stored) n = stored;

    // sums over the latest n samples, newest first
    s1 = 0;
    s2 = 0;
    for (k = 0; k < n; k++) begin
      idx = wptr - 6'd1 - 6'(k);
      v = hist[idx];
      s1 += v;
      s2 += v * v;
    end

    res.sample = smp;
    res.mean = 16'(s1 / n);
    res.sd = '0;
    if (n >= 2) begin
      var_q = (n * s2 - s1 * s1) / (n * (n - 1));
      root = 0;
      for (k = 31; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= var_q) root = trial;
      end
      res.sd = (root > 64'(SD_MAX)) ? SD_MAX : root[SAMPLE_W-1:0];
    end
    res.used = N_W'(n);
    res.total = total;
    return 1'b1;
  endfunction

  function automatic dir_row_t row(input logic [CMD_W-1:0] cmd,
                                   input logic [BYTE_W-1:0] data,
                                   input bit typed = 1'b0,
                                   input logic [SAMPLE_W-1:0] sample = '0,
                                   input logic [SAMPLE_W-1:0] mean = '0,
                                   input logic [SAMPLE_W-1:0] sd = '0,
                                   input logic [N_W-1:0] used = '0,
                                   input logic [TOTAL_W-1:0] tot = '0);
    dir_row_t r;
    r.cmd = cmd;
    r.data = data;
    r.typed = typed;
    r.want = '{pad: 1'b0, total: tot, used: used, sd: sd, mean: mean, sample: sample};
    return r;
  endfunction

  function automatic void note_failure(input string what, input stats_t want,
                                       input stats_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t mismatch (%s): exp smp=%h mean=%h sd=%h n=%0d tot=%0d pad=%b",
               $realtime, what, want.sample, want.mean, want.sd, want.used,
               want.total, want.pad);
      $display("    got smp=%h mean=%h sd=%h n=%0d tot=%0d pad=%b",
               got.sample, got.mean, got.sd, got.used, got.total, got.pad);
    end
  endfunction

  // One input transfer; entered and left at a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input bit typed, input stats_t want);
    stats_t got;
    bit     has;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = advance_deframer(cmd, data, got);
    if (has) stats_due.push_back(typed ? want : got);
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    send_item(cmd, data, 1'b0, '0);
  endtask

  // Stop sending and wait until every expected result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both registers back to back; block must be idle
  task automatic set_config(input logic [TICK_W-1:0] tmo, input logic [N_W-1:0] win);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_tmo = tmo;
    @(negedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data <= CFG_DATA_W'(win);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_win = win;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete byte pairs with short tick gaps, plus noise
  task automatic random_step();
    int r;
    int gap;
    r = $urandom_range(99);
    if (r < 70) begin
      send(CMD_BYTE, BYTE_W'($urandom_range(255)));
      if ($urandom_range(19) == 0 && cfg_tmo <= 200)
        gap = cfg_tmo + $urandom_range(1);
      else
        gap = $urandom_range(3);
      repeat (gap) send(CMD_TICK, BYTE_W'($urandom_range(255)));
      send(CMD_BYTE, BYTE_W'($urandom_range(255)));
    end else if (r < 80) begin
      send(CMD_BYTE, BYTE_W'($urandom_range(255)));
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) send(CMD_TICK, BYTE_W'($urandom_range(255)));
    end else if (r < 93) begin
      send(CMD_CLEAR, BYTE_W'($urandom_range(255)));
    end else if (r < 97) begin
      send(CMD_UNUSED, BYTE_W'($urandom_range(255)));
    end else begin
      send(CMD_TICK, BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input int count);
    int target;
    idle_pct = s_idle;
    stall_pct = r_stall;
    target = items_sent + count;
    while (items_sent < target) random_step();
  endtask

  // Receiver side
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got = stats_t'(m_tdata);
      if (stats_due.size() == 0) begin
        note_failure("no result expected", '0, mon_got);
      end else begin
        mon_want = stats_due.pop_front();
        if (mon_got.sample != mon_want.sample || mon_got.mean != mon_want.mean ||
            mon_got.sd != mon_want.sd || mon_got.used != mon_want.used ||
            mon_got.total != mon_want.total || mon_got.pad != mon_want.pad)
          note_failure("field", mon_want, mon_got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    int k;

    // directed rows, run with timeout 2 and window length zero
    dir_rows.push_back(row(CMD_UNUSED, 8'hAA));
    dir_rows.push_back(row(CMD_BYTE, 8'hFF));
    dir_rows.push_back(row(CMD_BYTE, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0, 7'd1, 32'd1));
    dir_rows.push_back(row(CMD_BYTE, 8'h00));
    dir_rows.push_back(row(CMD_BYTE, 8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0, 7'd1, 32'd2));
    // clear drops the pending high byte
    dir_rows.push_back(row(CMD_BYTE, 8'h12));
    dir_rows.push_back(row(CMD_CLEAR, 8'h00));
    dir_rows.push_back(row(CMD_BYTE, 8'h80));
    dir_rows.push_back(row(CMD_BYTE, 8'h01, 1'b1, 16'h8001, 16'h8001, 16'h0, 7'd1, 32'd3));
    // gap equal to the timeout keeps the byte
    dir_rows.push_back(row(CMD_BYTE, 8'h55));
    dir_rows.push_back(row(CMD_TICK, 8'hFF));
    dir_rows.push_back(row(CMD_TICK, 8'h00));
    dir_rows.push_back(row(CMD_BYTE, 8'h66, 1'b1, 16'h5566, 16'h5566, 16'h0, 7'd1, 32'd4));
    // gap one past the timeout drops it
    dir_rows.push_back(row(CMD_BYTE, 8'h77));
    dir_rows.push_back(row(CMD_TICK, 8'h00));
    dir_rows.push_back(row(CMD_TICK, 8'h00));
    dir_rows.push_back(row(CMD_TICK, 8'h00));
    dir_rows.push_back(row(CMD_BYTE, 8'h01));
    dir_rows.push_back(row(CMD_BYTE, 8'hFE, 1'b1, 16'h01FE, 16'h01FE, 16'h0, 7'd1, 32'd5));
    // unused command between the two bytes changes nothing
    dir_rows.push_back(row(CMD_BYTE, 8'h10));
    dir_rows.push_back(row(CMD_UNUSED, 8'hFF));
    dir_rows.push_back(row(CMD_BYTE, 8'h20, 1'b1, 16'h1020, 16'h1020, 16'h0, 7'd1, 32'd6));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 6;
    stall_pct = 86;
    set_config(16'd2, 7'd0);
    for (i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

    // sender rarely idles, receiver mostly stalls; largest timeout, window equal to the history depth
    drain();
    set_config(TICK_MAX, 7'd64);
    run_phase(6, 86, 550);

    // sender mostly idles; window above the history depth
    drain();
    set_config(16'd1, 7'd127);
    run_phase(86, 6, 550);

    // no idling on either side
    drain();
    set_config(TIMEOUT_RESET, WINDOW_RESET);
    run_phase(0, 0, 350);
    for (k = 0; k < 3; k++) begin
      drain();
      set_config(TICK_W'($urandom_range(1, 12)), N_W'($urandom_range(2, 63)));
      run_phase(0, 0, 160);
    end

    drain();
    repeat (200) @(negedge clk);
    if (failures == 0 && stats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
